// File: rtl/core/dts_pkg.sv
// Shared widths and result status codes for the dependency order block.
package dts_pkg;

  localparam int ID_W     = 6;
  localparam int STATUS_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_CYCLE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

endpackage

// File: rtl/core/dts_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
module dts_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dependency_topological_sort.sv
// Top level of the dependency order block: graph load and Kahn sort sequencer.
//
//   channel   direction  handshake               payload
//   request   in         in_valid / in_stall     node_from, node_to, has_edge, last
//   result    out        out_valid / out_stall   node_id, status, end_of_order
//
// A load request does one read-modify-write of the node table per node touched: the
// source, and also the target when it carries an edge; the node table has a single read port.
// The sort after a request with last set walks the edge store once for every node taken
// off the ready queue.
// After reset, and after every run, a clearing sweep zeroes the node table; in_stall
// stays high during it. rst is synchronous and active high.
// A stalled result holds in the output register; the sequencer waits on it.
module dependency_topological_sort #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [dts_pkg::ID_W-1:0]     node_from,
  input  logic [dts_pkg::ID_W-1:0]     node_to,
  input  logic                         has_edge,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [dts_pkg::ID_W-1:0]     node_id,
  output logic [dts_pkg::STATUS_W-1:0] status,
  output logic                         end_of_order
);

  localparam int IDW     = dts_pkg::ID_W;
  localparam int NIDX_W  = $clog2(MAX_NODES);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int EIDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W  = $clog2(MAX_EDGES + 1);
  localparam int DEG_W   = ECNT_W;
  localparam int NWORD_W = DEG_W + 1;
  localparam int EWORD_W = 2 * IDW;

  // Sequencer states
  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_FROM_WR  = 4'd2;
  localparam logic [3:0] S_TO_WR    = 4'd3;
  localparam logic [3:0] S_START    = 4'd4;
  localparam logic [3:0] S_SCAN     = 4'd5;
  localparam logic [3:0] S_POP      = 4'd6;
  localparam logic [3:0] S_POP_WAIT = 4'd7;
  localparam logic [3:0] S_EDGE_RD  = 4'd8;
  localparam logic [3:0] S_EDGE_CHK = 4'd9;
  localparam logic [3:0] S_DEG_UPD  = 4'd10;
  localparam logic [3:0] S_CHECK    = 4'd11;
  localparam logic [3:0] S_OUT_RD   = 4'd12;
  localparam logic [3:0] S_OUT_LD   = 4'd13;
  localparam logic [3:0] S_WAIT     = 4'd14;

  logic [3:0]        state;
  logic [NIDX_W-1:0] clr_idx;
  logic [ECNT_W-1:0] edge_count;
  logic              overflow;
  logic [NCNT_W-1:0] present_count;
  logic [NCNT_W-1:0] head;
  logic [NCNT_W-1:0] tail;
  logic [ECNT_W-1:0] e_idx;
  logic [NCNT_W-1:0] scan_idx;
  logic              scan_v;
  logic [NCNT_W-1:0] scan_n;
  logic [IDW-1:0]    cur_node;
  logic [NCNT_W-1:0] out_idx;

  // Captured load request
  logic [IDW-1:0]    it_from;
  logic [IDW-1:0]    it_to;
  logic              it_edge_ok;
  logic              it_last;

  // Node table: {present, in_degree} per node
  logic                nm_we;
  logic [NIDX_W-1:0]   nm_waddr;
  logic [NWORD_W-1:0]  nm_wdata;
  logic [NIDX_W-1:0]   nm_raddr;
  logic [NWORD_W-1:0]  nm_rdata;
  logic                nm_present;
  logic [DEG_W-1:0]    nm_deg;

  // Edge store: {from, to} per edge
  logic                em_we;
  logic [EIDX_W-1:0]   em_waddr;
  logic [EWORD_W-1:0]  em_wdata;
  logic [EIDX_W-1:0]   em_raddr;
  logic [EWORD_W-1:0]  em_rdata;
  logic [IDW-1:0]      edge_from;
  logic [IDW-1:0]      edge_to;

  // Ready queue; its filled part is also the finished order
  logic                qm_we;
  logic [NIDX_W-1:0]   qm_waddr;
  logic [IDW-1:0]      qm_wdata;
  logic [NIDX_W-1:0]   qm_raddr;
  logic [IDW-1:0]      qm_rdata;

  logic from_ok;
  logic to_ok;
  logic edge_ok;
  logic store_edge;
  logic queue_room;
  logic scan_push;
  logic deg_push;

  assign in_stall   = (state != S_IDLE);

  assign nm_present = nm_rdata[DEG_W];
  assign nm_deg     = nm_rdata[DEG_W-1:0];
  assign edge_from  = em_rdata[EWORD_W-1:IDW];
  assign edge_to    = em_rdata[IDW-1:0];

  // Ids at or above MAX_NODES drop the item (source) or the edge (target)
  assign from_ok    = (32'(node_from) < 32'(MAX_NODES));
  assign to_ok      = (32'(node_to) < 32'(MAX_NODES));
  assign edge_ok    = has_edge && (node_to != node_from) && to_ok;

  assign store_edge = it_edge_ok && (edge_count < ECNT_W'(MAX_EDGES));
  assign queue_room = (tail < NCNT_W'(MAX_NODES));
  assign scan_push  = scan_v && nm_present && (nm_deg == '0) && queue_room;
  assign deg_push   = (nm_deg == DEG_W'(1)) && queue_room;

  // Memory port steering
  always_comb begin
    nm_we    = 1'b0;
    nm_waddr = clr_idx;
    nm_wdata = '0;
    nm_raddr = NIDX_W'(node_from);
    em_we    = 1'b0;
    em_waddr = edge_count[EIDX_W-1:0];
    em_wdata = {it_from, it_to};
    em_raddr = e_idx[EIDX_W-1:0];
    qm_we    = 1'b0;
    qm_waddr = tail[NIDX_W-1:0];
    qm_wdata = IDW'(scan_n);
    qm_raddr = head[NIDX_W-1:0];
    unique case (state)
      S_CLEAR: begin
        nm_we = 1'b1;
      end
      S_FROM_WR: begin
        // Mark the source, bump its in-degree if the edge is stored, and fetch the target for next cycle
        nm_we    = 1'b1;
        nm_waddr = NIDX_W'(it_from);
        nm_wdata = {1'b1, nm_deg + DEG_W'(store_edge)};
        em_we    = store_edge;
        nm_raddr = NIDX_W'(it_to);
      end
      S_TO_WR: begin
        nm_we    = 1'b1;
        nm_waddr = NIDX_W'(it_to);
        nm_wdata = {1'b1, nm_deg};
      end
      S_SCAN: begin
        nm_raddr = NIDX_W'(scan_idx);
        qm_we    = scan_push;
      end
      S_EDGE_CHK: begin
        nm_raddr = NIDX_W'(edge_from);
      end
      S_DEG_UPD: begin
        nm_we    = (nm_deg != '0);
        nm_waddr = NIDX_W'(edge_from);
        nm_wdata = {nm_present, nm_deg - DEG_W'(1)};
        qm_we    = deg_push;
        qm_wdata = edge_from;
      end
      S_OUT_RD: begin
        qm_raddr = out_idx[NIDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_idx       <= '0;
      edge_count    <= '0;
      overflow      <= 1'b0;
      present_count <= '0;
      head          <= '0;
      tail          <= '0;
      scan_v        <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      // Drop the result once taken
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          // Sweep the node table back to zero and reset the run counters
          clr_idx       <= clr_idx + NIDX_W'(1);
          edge_count    <= '0;
          overflow      <= 1'b0;
          present_count <= '0;
          head          <= '0;
          tail          <= '0;
          if (clr_idx == NIDX_W'(MAX_NODES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            it_from    <= node_from;
            it_to      <= node_to;
            it_edge_ok <= edge_ok;
            it_last    <= last;
            if (from_ok) begin
              state <= S_FROM_WR;
            end else if (last) begin
              state <= S_START;
            end
          end
        end
        S_FROM_WR: begin
          if (!nm_present) begin
            present_count <= present_count + NCNT_W'(1);
          end
          if (store_edge) begin
            edge_count <= edge_count + ECNT_W'(1);
          end else if (it_edge_ok) begin
            overflow <= 1'b1;
          end
          if (it_edge_ok) begin
            state <= S_TO_WR;
          end else begin
            state <= it_last ? S_START : S_IDLE;
          end
        end
        S_TO_WR: begin
          if (!nm_present) begin
            present_count <= present_count + NCNT_W'(1);
          end
          state <= it_last ? S_START : S_IDLE;
        end
        S_START: begin
          scan_idx <= '0;
          scan_v   <= 1'b0;
          if (present_count == '0) begin
            // Empty graph: no result, just clear
            clr_idx <= '0;
            state   <= S_CLEAR;
          end else if (overflow) begin
            node_id      <= '0;
            status       <= dts_pkg::ST_OVERFLOW;
            end_of_order <= 1'b1;
            out_valid    <= 1'b1;
            state        <= S_WAIT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Seed the queue in ascending id order, one node read per cycle
          scan_v   <= (scan_idx < NCNT_W'(MAX_NODES));
          scan_n   <= scan_idx;
          scan_idx <= scan_idx + NCNT_W'(1);
          if (scan_push) begin
            tail <= tail + NCNT_W'(1);
          end
          if (scan_idx == NCNT_W'(MAX_NODES)) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          state <= (head == tail) ? S_CHECK : S_POP_WAIT;
        end
        S_POP_WAIT: begin
          cur_node <= qm_rdata;
          head     <= head + NCNT_W'(1);
          e_idx    <= '0;
          state    <= S_EDGE_RD;
        end
        S_EDGE_RD: begin
          state <= (e_idx == edge_count) ? S_POP : S_EDGE_CHK;
        end
        S_EDGE_CHK: begin
          if (edge_to == cur_node) begin
            state <= S_DEG_UPD;
          end else begin
            e_idx <= e_idx + ECNT_W'(1);
            state <= S_EDGE_RD;
          end
        end
        S_DEG_UPD: begin
          if (deg_push) begin
            tail <= tail + NCNT_W'(1);
          end
          e_idx <= e_idx + ECNT_W'(1);
          state <= S_EDGE_RD;
        end
        S_CHECK: begin
          if (head != present_count) begin
            node_id      <= '0;
            status       <= dts_pkg::ST_CYCLE;
            end_of_order <= 1'b1;
            out_valid    <= 1'b1;
            state        <= S_WAIT;
          end else begin
            out_idx <= '0;
            state   <= S_OUT_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_LD;
        end
        S_OUT_LD: begin
          node_id      <= qm_rdata;
          status       <= dts_pkg::ST_OK;
          end_of_order <= ((out_idx + NCNT_W'(1)) == head);
          out_valid    <= 1'b1;
          state        <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall) begin
            if (end_of_order) begin
              clr_idx <= '0;
              state   <= S_CLEAR;
            end else begin
              out_idx <= out_idx + NCNT_W'(1);
              state   <= S_OUT_RD;
            end
          end
        end
        default: begin
          clr_idx <= '0;
          state   <= S_CLEAR;
        end
      endcase
    end
  end

  dts_ram #(.DEPTH(MAX_NODES), .WIDTH(NWORD_W)) u_node_ram (
    .clk   (clk),
    .we    (nm_we),
    .waddr (nm_waddr),
    .wdata (nm_wdata),
    .raddr (nm_raddr),
    .rdata (nm_rdata)
  );

  dts_ram #(.DEPTH(MAX_EDGES), .WIDTH(EWORD_W)) u_edge_ram (
    .clk   (clk),
    .we    (em_we),
    .waddr (em_waddr),
    .wdata (em_wdata),
    .raddr (em_raddr),
    .rdata (em_rdata)
  );

  dts_ram #(.DEPTH(MAX_NODES), .WIDTH(IDW)) u_queue_ram (
    .clk   (clk),
    .we    (qm_we),
    .waddr (qm_waddr),
    .wdata (qm_wdata),
    .raddr (qm_raddr),
    .rdata (qm_rdata)
  );

endmodule

// File: rtl/core/dts_checker.sv
// Port-level checks for the dependency order block, bound to its top level.
module dts_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         last,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [dts_pkg::ID_W-1:0]     node_id,
  input logic [dts_pkg::STATUS_W-1:0] status,
  input logic                         end_of_order
);

  // No request is taken while a result is pending
  a_busy_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted while a result is pending");

  // An error result is the single, final result of a run
  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != dts_pkg::ST_OK) |-> end_of_order && (node_id == '0))
    else $error("error result not final or node_id nonzero");

  // A non-final load request produces no result
  a_no_result_on_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last |=> !out_valid)
    else $error("result after a non-final request");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_id) && $stable(status)
      && $stable(end_of_order))
    else $error("stalled result changed");

endmodule

bind dependency_topological_sort dts_checker u_dts_checker (.*);
